// ----- hdl/ppu_pkg.sv -----
// Package for the particle pool update block: item types, pool sizing and queue codes.
// No dependencies.
`timescale 1ns / 1ps
package ppu_pkg;

	localparam int POOL_SIZE = 64;
	localparam int SLOT_W = 6;
	localparam int LIFE_W = 24;

	typedef enum logic {
		OP_EMIT = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		logic                operation;
		logic signed [31:0]  start_x;
		logic signed [31:0]  start_y;
		logic signed [31:0]  speed_x;
		logic signed [31:0]  speed_y;
		logic [23:0]         lifespan;
		logic [15:0]         begin_size;
		logic [15:0]         end_size;
		logic [31:0]         tint_rgba;
		logic [23:0]         step_time;
	} item_in_t;

	typedef struct packed {
		logic [5:0]          slot;
		logic signed [31:0]  draw_x;
		logic signed [31:0]  draw_y;
		logic [15:0]         draw_size;
		logic [31:0]         draw_rgba;
		logic                last;
	} item_out_t;

	// Command passed from the front part to the back part.
	typedef struct packed {
		op_t                 op;
		logic [SLOT_W-1:0]   slot;
		item_in_t            item;
	} cmd_t;

	// Wrap a slot index at the pool size.
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		logic [SLOT_W:0] n;
		n = {1'b0, s} + 1'b1;
		next_slot = (n >= (SLOT_W+1)'(POOL_SIZE)) ? '0 : n[SLOT_W-1:0];
	endfunction

endpackage

// ----- hdl/ppu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ppu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/ppu_front.sv -----
// Front part: accepts items, assigns emit slots from the ring pointer, and queues commands.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
module ppu_front import ppu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  item_in_t item_in,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     cmd_pop
);

	logic [SLOT_W-1:0] wp_q;
	cmd_t              buf_q [2];
	logic              rd_q, wr_q;
	logic [1:0]        cnt_q;
	logic              push;

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_q];

	// Two-entry command queue and the ring write pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
				if (item_in.operation == OP_EMIT) wp_q <= next_slot(wp_q);
			end
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	// Queue payload.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q].op   <= op_t'(item_in.operation);
			buf_q[wr_q].slot <= wp_q;
			buf_q[wr_q].item <= item_in;
		end
	end

endmodule

// ----- hdl/ppu_div.sv -----
// Restoring divider: quotient of a 40-bit numerator by a 24-bit divisor, one bit per cycle.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
module ppu_div import ppu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [39:0] num,
	input  logic [23:0] den,
	output logic        done,
	output logic [39:0] quo
);

	logic [39:0] q_q;
	logic [24:0] r_q;
	logic [23:0] d_q;
	logic [5:0]  n_q;
	logic        run_q;
	logic [25:0] trial;

	assign trial = {r_q, q_q[39]} - {2'b0, d_q};
	assign quo   = q_q;

	// One quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			n_q   <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				n_q   <= 6'd40;
			end else if (run_q) begin
				n_q <= n_q - 1'b1;
				if (n_q == 6'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (run_q) begin
			if (!trial[25]) begin
				r_q <= trial[24:0];
				q_q <= {q_q[38:0], 1'b1};
			end else begin
				r_q <= {r_q[23:0], q_q[39]};
				q_q <= {q_q[38:0], 1'b0};
			end
		end
	end

endmodule

// ----- hdl/ppu_back.sv -----
// Back part: writes emitted particles and walks the pool on ticks, producing results.
// Depends on ppu_pkg, ppu_ram and ppu_div.
`timescale 1ns / 1ps
module ppu_back import ppu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output logic      result_valid,
	output item_out_t result
);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_READ, S_MUL, S_POS, S_DA, S_DS, S_OUT
	} state_t;

	state_t            st_q;
	logic [POOL_SIZE-1:0] occ_q;
	logic [SLOT_W-1:0] idx_q;
	logic [23:0]       step_q;
	logic              any_q;
	logic              have_q;
	item_out_t         pend_q;
	item_out_t         pend_fin;

	// Memory words.
	logic              we;
	logic [SLOT_W-1:0] waddr, raddr;
	logic [23:0]       wl, rl, rt;
	logic [31:0]       wpx, wpy, rpx, rpy, rvx, rvy, wcol, rcol;
	logic [15:0]       rs0, rs1;
	logic              emit_w;

	ppu_ram #(.WIDTH(24), .DEPTH(POOL_SIZE)) u_left (.clk, .we, .waddr, .wdata(wl),
		.raddr, .rdata(rl));
	ppu_ram #(.WIDTH(24), .DEPTH(POOL_SIZE)) u_tot (.clk, .we(emit_w), .waddr,
		.wdata(cmd.item.lifespan), .raddr, .rdata(rt));
	ppu_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_px (.clk, .we, .waddr, .wdata(wpx),
		.raddr, .rdata(rpx));
	ppu_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_py (.clk, .we, .waddr, .wdata(wpy),
		.raddr, .rdata(rpy));
	ppu_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_vx (.clk, .we(emit_w), .waddr,
		.wdata(cmd.item.speed_x), .raddr, .rdata(rvx));
	ppu_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_vy (.clk, .we(emit_w), .waddr,
		.wdata(cmd.item.speed_y), .raddr, .rdata(rvy));
	ppu_ram #(.WIDTH(16), .DEPTH(POOL_SIZE)) u_s0 (.clk, .we(emit_w), .waddr,
		.wdata(cmd.item.begin_size), .raddr, .rdata(rs0));
	ppu_ram #(.WIDTH(16), .DEPTH(POOL_SIZE)) u_s1 (.clk, .we(emit_w), .waddr,
		.wdata(cmd.item.end_size), .raddr, .rdata(rs1));
	ppu_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_col (.clk, .we, .waddr, .wdata(wcol),
		.raddr, .rdata(rcol));

	// Working registers for one live slot.
	logic signed [56:0] mx_q, my_q;
	logic [23:0]        left_q, tot_q;
	logic [31:0]        px_q, py_q, col_q;
	logic [15:0]        s0_q, s1_q;
	logic [7:0]         alpha_q;
	logic [39:0]        sz_num_q;
	logic               wb_q;

	// Divider shared by alpha and size.
	logic        dgo, ddone;
	logic [39:0] dnum, dquo;
	ppu_div u_div (.clk, .arst_n, .go(dgo), .num(dnum), .den(tot_q), .done(ddone),
		.quo(dquo));

	// Floor shift then saturating add.
	function automatic logic [31:0] sat_add(input logic [31:0] p, input logic signed [56:0] m);
		logic signed [40:0] d, s;
		d = 41'(m >>> 16);
		s = 41'(signed'(p)) + d;
		if (s > 41'sd2147483647) sat_add = 32'h7FFF_FFFF;
		else if (s < -41'sd2147483648) sat_add = 32'h8000_0000;
		else sat_add = s[31:0];
	endfunction

	logic scan_live;
	logic last_live;
	logic [SLOT_W:0] nidx;
	logic [23:0]     left_c;
	assign scan_live = occ_q[idx_q];
	assign nidx = {1'b0, idx_q} + 1'b1;
	assign left_c = (left_q > tot_q) ? tot_q : left_q;

	assign emit_w  = (st_q == S_IDLE) && cmd_valid && (cmd.op == OP_EMIT);
	assign we      = emit_w || wb_q;
	assign waddr   = emit_w ? cmd.slot : idx_q;
	assign wl      = emit_w ? cmd.item.lifespan : left_q;
	assign wpx     = emit_w ? cmd.item.start_x : px_q;
	assign wpy     = emit_w ? cmd.item.start_y : py_q;
	assign wcol    = emit_w ? cmd.item.tint_rgba : col_q;
	assign raddr   = idx_q;
	assign cmd_pop = (st_q == S_IDLE) && cmd_valid;
	assign dgo     = (st_q == S_POS) || (st_q == S_DA && ddone);
	assign dnum    = (st_q == S_POS) ? {16'd0, left_q} * 40'd255 : sz_num_q;
	assign last_live = 1'b0;

	// The held result with its last flag set, for the end of a walk.
	always_comb begin
		pend_fin      = pend_q;
		pend_fin.last = 1'b1;
	end

	// Sequencer and result register. A slot result is held in pend_q until the
	// next live slot or the end of the walk decides its last flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			occ_q        <= '0;
			idx_q        <= '0;
			any_q        <= 1'b0;
			have_q       <= 1'b0;
			result_valid <= 1'b0;
			wb_q         <= 1'b0;
			step_q       <= '0;
			pend_q       <= '0;
			result       <= '0;
			mx_q         <= '0;
			my_q         <= '0;
			left_q       <= '0;
			tot_q        <= '0;
			px_q         <= '0;
			py_q         <= '0;
			col_q        <= '0;
			s0_q         <= '0;
			s1_q         <= '0;
			alpha_q      <= '0;
			sz_num_q     <= '0;
		end else begin
			result_valid <= 1'b0;
			wb_q         <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.op == OP_EMIT) begin
							occ_q[cmd.slot] <= 1'b1;
							result_valid    <= 1'b1;
							result <= '{slot: cmd.slot, draw_x: cmd.item.start_x,
								draw_y: cmd.item.start_y, draw_size: cmd.item.begin_size,
								draw_rgba: cmd.item.tint_rgba, last: 1'b1};
						end else if (any_q) begin
							idx_q  <= '0;
							step_q <= cmd.item.step_time;
							have_q <= 1'b0;
							st_q   <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_live) st_q <= S_READ;
					else if (nidx == (SLOT_W+1)'(POOL_SIZE)) begin
						if (have_q) begin
							result       <= pend_fin;
							result_valid <= 1'b1;
						end
						st_q <= S_IDLE;
					end else idx_q <= nidx[SLOT_W-1:0];
				end
				S_READ: begin
					st_q <= S_MUL;
				end
				S_MUL: begin
					if (rl == 24'd0) begin
						occ_q[idx_q] <= 1'b0;
						if (nidx == (SLOT_W+1)'(POOL_SIZE)) begin
							if (have_q) begin
								result       <= pend_fin;
								result_valid <= 1'b1;
							end
							st_q <= S_IDLE;
						end else begin
							idx_q <= nidx[SLOT_W-1:0];
							st_q  <= S_SCAN;
						end
					end else begin
						mx_q   <= signed'(rvx) * signed'({1'b0, step_q});
						my_q   <= signed'(rvy) * signed'({1'b0, step_q});
						left_q <= (rl > step_q) ? rl - step_q : 24'd0;
						tot_q  <= rt;
						px_q   <= rpx;
						py_q   <= rpy;
						col_q  <= rcol;
						s0_q   <= rs0;
						s1_q   <= rs1;
						st_q   <= S_POS;
					end
				end
				S_POS: begin
					if (left_q > tot_q) left_q <= tot_q;
					px_q     <= sat_add(px_q, mx_q);
					py_q     <= sat_add(py_q, my_q);
					sz_num_q <= 40'(s1_q) * 40'(tot_q - left_c) + 40'(s0_q) * 40'(left_c);
					st_q     <= S_DA;
				end
				S_DA: begin
					if (ddone) begin
						alpha_q <= dquo[7:0];
						st_q    <= S_DS;
					end
				end
				S_DS: begin
					if (ddone) begin
						if (have_q) begin
							result       <= pend_q;
							result_valid <= 1'b1;
						end
						pend_q <= '{slot: idx_q, draw_x: px_q, draw_y: py_q,
							draw_size: dquo[15:0], draw_rgba: {col_q[31:8], alpha_q},
							last: last_live};
						col_q  <= {col_q[31:8], alpha_q};
						have_q <= 1'b1;
						wb_q   <= 1'b1;
						st_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (nidx == (SLOT_W+1)'(POOL_SIZE)) begin
						result       <= pend_fin;
						result_valid <= 1'b1;
						st_q         <= S_IDLE;
					end else begin
						idx_q <= nidx[SLOT_W-1:0];
						st_q  <= S_SCAN;
					end
				end
				default: st_q <= S_IDLE;
			endcase
			any_q <= |occ_q || emit_w;
		end
	end

endmodule

// ----- hdl/particle_pool_update_top.sv -----
// Particle ring pool update, top level. Emit: one result per emit, produced when the back part is idle.
// Tick: a walk over every slot that skips empty slots, frees spent ones and updates each live
// slot with two divides, alpha then size. Two commands may be queued ahead of the back part;
// busy rises when the queue is full.
// Reset clears occupancy and the write pointer at once; the receiver cannot stall.
// Depends on ppu_pkg, ppu_front and ppu_back.
`timescale 1ns / 1ps
module particle_pool_update_top import ppu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  item_in_t  item_in,
	output logic      result_valid,
	output item_out_t result
);

	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	ppu_front u_front (.clk, .arst_n, .start, .busy, .item_in, .cmd_valid, .cmd, .cmd_pop);
	ppu_back  u_back  (.clk, .arst_n, .cmd_valid, .cmd, .cmd_pop, .result_valid, .result);

endmodule

// ----- verif/ppu_checker.sv -----
// Checker for the particle pool update block: watches the command and result channels,
// keeps its own copy of the particle pool, and compares every result field by field.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
module ppu_checker import ppu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  item_in_t  item_in,
	input  logic      result_valid,
	input  item_out_t result,
	output int        errors,
	output int        pending
);

	// Shadow copy of the pool.
	logic               live [POOL_SIZE];
	logic [SLOT_W-1:0]  wr_slot;
	logic [23:0]        left_q [POOL_SIZE];
	logic [23:0]        total_q [POOL_SIZE];
	logic [31:0]        pos_x [POOL_SIZE];
	logic [31:0]        pos_y [POOL_SIZE];
	logic [31:0]        vel_x [POOL_SIZE];
	logic [31:0]        vel_y [POOL_SIZE];
	logic [15:0]        size_a [POOL_SIZE];
	logic [15:0]        size_b [POOL_SIZE];
	logic [31:0]        tint [POOL_SIZE];

	item_out_t sprite_q[$];

	// Move one coordinate by velocity times step, floored and saturated.
	function automatic logic [31:0] move_coord(input logic [31:0] p, input logic [31:0] v,
			input logic [23:0] dt);
		longint prod;
		longint sum;
		prod = longint'(signed'(v)) * longint'({8'd0, dt});
		sum = longint'(signed'(p)) + (prod >>> 16);
		if (sum > 64'sd2147483647)
			sum = 64'sd2147483647;
		if (sum < -64'sd2147483648)
			sum = -64'sd2147483648;
		return sum[31:0];
	endfunction

	// Work out the sprites that one accepted item produces.
	task automatic predict_sprites(input item_in_t it);
		item_out_t o;
		logic [63:0] lf;
		logic [63:0] tot;
		logic [63:0] alpha;
		logic [63:0] sz;
		int first;
		if (it.operation == OP_EMIT) begin
			live[wr_slot] = 1'b1;
			pos_x[wr_slot] = it.start_x;
			pos_y[wr_slot] = it.start_y;
			vel_x[wr_slot] = it.speed_x;
			vel_y[wr_slot] = it.speed_y;
			left_q[wr_slot] = it.lifespan;
			total_q[wr_slot] = it.lifespan;
			size_a[wr_slot] = it.begin_size;
			size_b[wr_slot] = it.end_size;
			tint[wr_slot] = it.tint_rgba;
			o.slot = wr_slot;
			o.draw_x = it.start_x;
			o.draw_y = it.start_y;
			o.draw_size = it.begin_size;
			o.draw_rgba = it.tint_rgba;
			o.last = 1'b1;
			sprite_q.push_back(o);
			wr_slot = (wr_slot == SLOT_W'(POOL_SIZE - 1)) ? '0 : wr_slot + 1'b1;
		end else begin
			first = sprite_q.size();
			for (int i = 0; i < POOL_SIZE; i++) begin
				if (!live[i] || left_q[i] == 0)
					continue;
				left_q[i] = (left_q[i] > it.step_time) ? left_q[i] - it.step_time : '0;
				pos_x[i] = move_coord(pos_x[i], vel_x[i], it.step_time);
				pos_y[i] = move_coord(pos_y[i], vel_y[i], it.step_time);
				lf = left_q[i];
				tot = total_q[i];
				if (tot == 0) begin
					tot = 1;
					lf = 0;
				end
				if (lf > tot)
					lf = tot;
				alpha = (lf * 255) / tot;
				tint[i][7:0] = alpha[7:0];
				sz = (64'(size_b[i]) * (tot - lf) + 64'(size_a[i]) * lf) / tot;
				o.slot = SLOT_W'(i);
				o.draw_x = pos_x[i];
				o.draw_y = pos_y[i];
				o.draw_size = sz[15:0];
				o.draw_rgba = tint[i];
				o.last = 1'b0;
				sprite_q.push_back(o);
			end
			// The final sprite of a tick carries the last mark.
			if (sprite_q.size() > first)
				sprite_q[sprite_q.size() - 1].last = 1'b1;
		end
	endtask

	// Prediction on accepted items and comparison on every result.
	always @(posedge clk or negedge arst_n) begin
		item_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++)
				live[i] = 1'b0;
			wr_slot = '0;
			errors = 0;
			pending = sprite_q.size();
		end else begin
			if (result_valid) begin
				if (sprite_q.size() == 0) begin
					$error("unexpected result for slot %0d", result.slot);
					errors++;
				end else begin
					want = sprite_q.pop_front();
					if (result.slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, result.slot);
						errors++;
					end
					if (result.draw_x !== want.draw_x) begin
						$error("draw_x: expected %h, got %h", want.draw_x, result.draw_x);
						errors++;
					end
					if (result.draw_y !== want.draw_y) begin
						$error("draw_y: expected %h, got %h", want.draw_y, result.draw_y);
						errors++;
					end
					if (result.draw_size !== want.draw_size) begin
						$error("draw_size: expected %h, got %h", want.draw_size,
							result.draw_size);
						errors++;
					end
					if (result.draw_rgba !== want.draw_rgba) begin
						$error("draw_rgba: expected %h, got %h", want.draw_rgba,
							result.draw_rgba);
						errors++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, result.last);
						errors++;
					end
				end
			end
			if (start && !busy)
				predict_sprites(item_in);
			pending = sprite_q.size();
		end
	end

endmodule

// ----- verif/tb_particle_pool_update_top.sv -----
// Testbench top for the particle pool update block: drives emit and tick items with
// random gaps and gives the verdict. Depends on ppu_pkg, ppu_checker and the block.
`timescale 1ns / 1ps
module tb_particle_pool_update_top;
	import ppu_pkg::*;

	localparam int ITEM_COUNT = 450;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 6000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	item_in_t  item_in;
	logic      result_valid;
	item_out_t result;
	int        errors;
	int        pending;
	int        idle_cycles;

	particle_pool_update_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item_in(item_in),
		.result_valid(result_valid),
		.result(result)
	);

	ppu_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item_in(item_in),
		.result_valid(result_valid),
		.result(result),
		.errors(errors),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Stop the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic item_in_t noise_item();
		item_in_t it;
		it.operation = OP_EMIT;
		it.start_x = $urandom;
		it.start_y = $urandom;
		it.speed_x = $urandom;
		it.speed_y = $urandom;
		it.lifespan = 24'($urandom);
		it.begin_size = 16'($urandom);
		it.end_size = 16'($urandom);
		it.tint_rgba = $urandom;
		it.step_time = 24'($urandom);
		return it;
	endfunction

	function automatic item_in_t emit_item(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] vx, input logic [31:0] vy, input logic [23:0] life,
			input logic [15:0] sa, input logic [15:0] sb, input logic [31:0] rgba);
		item_in_t it;
		it = noise_item();
		it.start_x = x;
		it.start_y = y;
		it.speed_x = vx;
		it.speed_y = vy;
		it.lifespan = life;
		it.begin_size = sa;
		it.end_size = sb;
		it.tint_rgba = rgba;
		return it;
	endfunction

	function automatic item_in_t tick_item(input logic [23:0] dt);
		item_in_t it;
		it = noise_item();
		it.operation = OP_TICK;
		it.step_time = dt;
		return it;
	endfunction

	// Mostly back to back, sometimes short pauses, rarely long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	// Present one item and hold it until the block takes it.
	task automatic send_item(input item_in_t it);
		int gap;
		start <= 1'b1;
		item_in <= it;
		do
			@(negedge clk);
		while (busy);
		@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	initial begin
		item_in_t it;
		int sent;
		arst_n = 1'b0;
		start = 1'b0;
		item_in = '0;
		idle_cycles = 0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes, saturation, dying slots and the empty pool.
		send_item(tick_item(24'h000100));
		send_item(emit_item(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			24'hffffff, 16'hffff, 16'h0000, 32'hffffffff));
		send_item(emit_item('0, '0, '0, '0, 24'h000001, 16'h0000, 16'hffff, 32'h0));
		// A zero lifespan is stored but never ticks.
		send_item(emit_item(32'h00010000, 32'hffff0000, 32'h00020000, 32'h0, 24'h0,
			16'h1234, 16'h4321, 32'h11223344));
		send_item(emit_item(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			24'h030000, 16'h0100, 16'h0800, 32'haabbccdd));
		send_item(tick_item(24'h000000));
		send_item(tick_item(24'h008000));
		send_item(tick_item(24'hffffff));
		send_item(tick_item(24'h010000));
		send_item(emit_item(32'h00050000, 32'hfffb0000, 32'hfffe8000, 32'h00018000,
			24'h020000, 16'h0400, 16'h0100, 32'h80402010));
		send_item(emit_item(32'h12345678, 32'h9abcdef0, 32'h00001000, 32'hfffff000,
			24'h000010, 16'hffff, 16'hffff, 32'h01020304));
		send_item(tick_item(24'h000008));
		send_item(tick_item(24'h000008));
		send_item(tick_item(24'h018000));
		send_item(tick_item(24'h018000));
		sent = 15;

		// Random part: mostly emits with short lives, ticks that age them.
		while (sent < ITEM_COUNT) begin
			if ($urandom_range(99) < 72) begin
				it = noise_item();
				if ($urandom_range(7) != 0)
					it.lifespan = 24'($urandom_range(1, 24'h030000));
				else if (it.lifespan == 0)
					it.lifespan = 24'h800000;
			end else begin
				it = tick_item($urandom_range(9) == 0 ? 24'($urandom)
					: 24'($urandom_range(0, 24'h008000)));
			end
			send_item(it);
			sent++;
		end
		start <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
